>>> sv/ir_range_linearize_kalman_assert.svh
// ----------------------------------------------------------------------------
// IR ranger Kalman filter - assertion macros
// Clocked assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef IR_RANGE_LINEARIZE_KALMAN_ASSERT_SVH
`define IR_RANGE_LINEARIZE_KALMAN_ASSERT_SVH

// checked outside reset
`define IRLK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked through reset as well
`define IRLK_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> sv/irk_pkg.sv
// ----------------------------------------------------------------------------
// IR ranger Kalman filter - package
// Widths, register indexes, reset values and polynomial coefficients.
// ----------------------------------------------------------------------------
package irk_pkg;

  localparam int MAX_CHANNELS_DEF = 16;
  localparam int RAW_BITS_DEF     = 10;

  localparam int CH_W      = 4;
  localparam int CNT_W     = 5;
  localparam int DIST_W    = 16;
  localparam int VAR_W     = 24;
  localparam int GAIN_W    = VAR_W + 1;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RING_RADIUS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INFINITY      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MEAS_VAR      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PROC_VAR      = 3'd5;

  localparam logic [CNT_W-1:0]  RST_CHANNEL_COUNT = 5'd11;
  localparam logic [DIST_W-1:0] RST_MAX_RANGE     = 16'd3277;
  localparam logic [DIST_W-1:0] RST_RING_RADIUS   = 16'd635;
  localparam logic [DIST_W-1:0] RST_INFINITY      = 16'd24576;
  localparam logic [VAR_W-1:0]  RST_MEAS_VAR      = 24'd419430;
  localparam logic [VAR_W-1:0]  RST_PROC_VAR      = 24'd16777;

  localparam logic [DIST_W-1:0] RST_ESTIMATE   = 16'd3277;
  localparam logic [VAR_W-1:0]  RST_COVARIANCE = 24'd419430;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;
  localparam logic [VAR_W-1:0]  VAR_MAX  = '1;
  localparam logic [GAIN_W-1:0] GAIN_ONE = 25'h100_0000;

  // polynomial datapath
  localparam int ACC_W       = 42;
  localparam int LO_W        = 21;
  localparam int POLY_ORDER  = 6;
  localparam int POLY_SHIFT  = 10;
  localparam int ACC_LIM_LOG = 40;
  localparam int OUT_SHIFT   = 12;
  localparam int POLY_LAT    = 2 * POLY_ORDER + 1;

  localparam logic signed [ACC_W-1:0] POLY_D [0:POLY_ORDER] = '{
    42'sd50649704, -42'sd807411384, 42'sd5893233862, -42'sd22534451749,
    42'sd46503365092, -42'sd48965240009, 42'sd20608893021
  };

  // gain divider
  localparam int DIV_BPS    = 2;
  localparam int DIV_STAGES = (GAIN_W + DIV_BPS - 1) / DIV_BPS;

endpackage

>>> sv/irk_ram.sv
// ----------------------------------------------------------------------------
// IR ranger Kalman filter - generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module irk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/irk_poly.sv
// ----------------------------------------------------------------------------
// IR ranger Kalman filter - linearising polynomial
// Pipelined Horner evaluation, two stages per coefficient, Q4.12 result.
// ----------------------------------------------------------------------------
module irk_poly #(
  parameter int RAW_BITS = irk_pkg::RAW_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [RAW_BITS-1:0]        raw_i,
  output logic [irk_pkg::DIST_W-1:0] dist_o
);
  import irk_pkg::*;

  localparam int HI_W = ACC_W - LO_W;
  localparam int HP_W = HI_W + RAW_BITS + 1;
  localparam int LP_W = LO_W + RAW_BITS;
  localparam int PW   = ACC_W + RAW_BITS + 1;
  localparam int RN   = 2 * POLY_ORDER - 1;

  localparam logic signed [PW-1:0] LIM_P =
    {{(PW-ACC_LIM_LOG-1){1'b0}}, 1'b1, {ACC_LIM_LOG{1'b0}}};
  localparam logic signed [PW-1:0] LIM_N = -LIM_P;

  logic [RAW_BITS-1:0]     raw_q [0:RN-1];
  logic signed [HP_W-1:0]  hp_q  [0:POLY_ORDER-1];
  logic [LP_W-1:0]         lp_q  [0:POLY_ORDER-1];
  logic signed [ACC_W-1:0] acc_q [1:POLY_ORDER];
  logic [DIST_W-1:0]       dist_q, dist_d;
  logic [ACC_W-1:0]        rnd;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      raw_q[0] <= raw_i;
      for (int j = 1; j < RN; j++) begin
        raw_q[j] <= raw_q[j-1];
      end
    end
  end

  for (genvar gi = 0; gi < POLY_ORDER; gi++) begin : g_step
    logic signed [ACC_W-1:0] acc_in;
    logic signed [HI_W-1:0]  hi;
    logic [LO_W-1:0]         lo;
    logic signed [PW-1:0]    sum, shr, nxt, acc_d;

    if (gi == 0) begin : g_first
      assign acc_in = POLY_D[POLY_ORDER];
    end else begin : g_rest
      assign acc_in = acc_q[gi];
    end

    assign hi = acc_in[ACC_W-1:LO_W];
    assign lo = acc_in[LO_W-1:0];

    // partial products of acc * raw
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        hp_q[gi] <= hi * $signed({1'b0, raw_q[2*gi]});
        lp_q[gi] <= lo * raw_q[2*gi];
      end
    end

    assign sum   = (PW'(hp_q[gi]) <<< LO_W) + $signed(PW'(lp_q[gi]));
    assign shr   = sum >>> POLY_SHIFT;
    assign nxt   = shr + PW'(POLY_D[POLY_ORDER-1-gi]);
    assign acc_d = (nxt > LIM_P) ? LIM_P : ((nxt < LIM_N) ? LIM_N : nxt);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_q[gi+1] <= ACC_W'(acc_d);
      end
    end
  end

  always_comb begin
    dist_d = '0;
    rnd    = $unsigned(acc_q[POLY_ORDER]) + ACC_W'(1 << (OUT_SHIFT - 1));
    if (acc_q[POLY_ORDER] > 0) begin
      if (rnd[ACC_W-1:OUT_SHIFT] > (ACC_W-OUT_SHIFT)'(DIST_MAX)) begin
        dist_d = DIST_MAX;
      end else begin
        dist_d = rnd[OUT_SHIFT+DIST_W-1:OUT_SHIFT];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dist_q <= dist_d;
    end
  end

  assign dist_o = dist_q;

endmodule

>>> sv/irk_div.sv
// ----------------------------------------------------------------------------
// IR ranger Kalman filter - gain divider
// Pipelined restoring division P1*2^24/(R+P1), two quotient bits a stage.
// ----------------------------------------------------------------------------
module irk_div (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [irk_pkg::VAR_W-1:0]  p1_i,
  input  logic [irk_pkg::VAR_W:0]    den_i,
  output logic [irk_pkg::GAIN_W-1:0] gain_o
);
  import irk_pkg::*;

  localparam int RW = VAR_W + 2;

  logic [RW-1:0]     rem_q  [1:DIV_STAGES-1];
  logic [VAR_W:0]    den_q  [1:DIV_STAGES-1];
  logic [GAIN_W-1:0] quo_q  [1:DIV_STAGES];
  logic              zero_q [1:DIV_STAGES];

  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_stage
    logic [RW-1:0]     rem_in, rem_d;
    logic [VAR_W:0]    den_in;
    logic [GAIN_W-1:0] quo_in, quo_d;
    logic              zero_in;

    if (k == 1) begin : g_first
      assign rem_in  = RW'(p1_i);
      assign den_in  = den_i;
      assign quo_in  = '0;
      assign zero_in = (den_i == '0);
    end else begin : g_rest
      assign rem_in  = rem_q[k-1];
      assign den_in  = den_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign zero_in = zero_q[k-1];
    end

    always_comb begin
      rem_d = rem_in;
      quo_d = quo_in;
      for (int j = 0; j < DIV_BPS; j++) begin
        if ((k - 1) * DIV_BPS + j < GAIN_W) begin
          if (rem_d >= RW'(den_in)) begin
            rem_d = rem_d - RW'(den_in);
            quo_d = {quo_d[GAIN_W-2:0], 1'b1};
          end else begin
            quo_d = {quo_d[GAIN_W-2:0], 1'b0};
          end
          rem_d = rem_d << 1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[k]  <= quo_d;
        zero_q[k] <= zero_in;
      end
    end

    if (k < DIV_STAGES) begin : g_keep
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= rem_d;
          den_q[k] <= den_in;
        end
      end
    end
  end

  // zero denominator gives zero gain
  assign gain_o = zero_q[DIV_STAGES] ? '0 : quo_q[DIV_STAGES];

endmodule

>>> sv/irk_kupd.sv
// ----------------------------------------------------------------------------
// IR ranger Kalman filter - state update
// Estimate correction K*(z-x) and covariance shrink P1*(1-K).
// ----------------------------------------------------------------------------
module irk_kupd (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [irk_pkg::DIST_W-1:0] dist_i,
  input  logic [irk_pkg::DIST_W-1:0] est_i,
  input  logic [irk_pkg::VAR_W-1:0]  p1_i,
  input  logic [irk_pkg::GAIN_W-1:0] gain_i,
  output logic [irk_pkg::DIST_W-1:0] est_o,
  output logic [irk_pkg::VAR_W-1:0]  p_o
);
  import irk_pkg::*;

  localparam int PROD_W = GAIN_W + DIST_W;
  localparam int PP_W   = VAR_W + GAIN_W;
  localparam int CORR_W = PROD_W - VAR_W;

  logic              neg_d, neg_q;
  logic [DIST_W-1:0] mag_d, est_q;
  logic [GAIN_W-1:0] omg_d;
  logic [PROD_W-1:0] prod_d, prod_q, prod_rnd;
  logic [PP_W-1:0]   pp_d, pp_q;
  logic [CORR_W-1:0] corr;
  logic [DIST_W+1:0] sum;

  always_comb begin
    neg_d  = (dist_i < est_i);
    mag_d  = neg_d ? (est_i - dist_i) : (dist_i - est_i);
    prod_d = gain_i * mag_d;
    omg_d  = GAIN_ONE - gain_i;
    pp_d   = p1_i * omg_d;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q  <= neg_d;
      est_q  <= est_i;
      prod_q <= prod_d;
      pp_q   <= pp_d;
    end
  end

  always_comb begin
    prod_rnd = prod_q + PROD_W'(1 << (VAR_W - 1));
    corr     = prod_rnd[PROD_W-1:VAR_W];
    sum      = (DIST_W+2)'(est_q) + (DIST_W+2)'(corr);
    if (neg_q) begin
      est_o = ((DIST_W+2)'(est_q) < (DIST_W+2)'(corr)) ? '0 : DIST_W'(est_q - corr);
    end else begin
      est_o = (sum > (DIST_W+2)'(DIST_MAX)) ? DIST_MAX : sum[DIST_W-1:0];
    end
    p_o = pp_q[2*VAR_W-1:VAR_W];
  end

endmodule

>>> sv/ir_range_linearize_kalman.sv
// ----------------------------------------------------------------------------
// IR ranger linearisation with per-channel scalar Kalman filter - top level
// Input beats carry channel, raw reading and scan end marker. The raw value
// is linearised to Q4.12 metres and filtered per channel; each beat yields
// one result beat on the output channel (slot, filtered and converted
// distance, scan end, bad channel flag). Registers are written through the
// plain write port; the user must write them only while the block is idle,
// and the block itself does not enforce this.
// Throughput: one beat per cycle. A beat whose channel matches a beat still
// between the state read and the state write-back (16 stages) is held off
// until that beat has written back; that span sets the repeat rate of one
// channel.
// Reset: pipeline empties, registers take reset values, per-channel state
// reads as its reset value through valid flags; no clearing sweep.
// Output stall: the whole pipeline holds and the input is stalled.
// ----------------------------------------------------------------------------
module ir_range_linearize_kalman #(
  parameter int MAX_CHANNELS = irk_pkg::MAX_CHANNELS_DEF,
  parameter int RAW_BITS     = irk_pkg::RAW_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [irk_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [irk_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [irk_pkg::CH_W-1:0]      channel_i,
  input  logic [RAW_BITS-1:0]           raw_reading_i,
  input  logic                          scan_end_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [irk_pkg::CH_W-1:0]      slot_o,
  output logic [irk_pkg::DIST_W-1:0]    filtered_distance_o,
  output logic [irk_pkg::DIST_W-1:0]    converted_distance_o,
  output logic                          scan_end_out_o,
  output logic                          bad_channel_o
);
  import irk_pkg::*;

  localparam int IW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int ST_W  = DIST_W + VAR_W;
  localparam int S_UPD = 1 + DIV_STAGES;
  localparam int S_WB  = S_UPD + 1;
  localparam int S_REP = S_WB + 1;
  localparam int NS    = S_REP + 1;

  // configuration
  logic [CNT_W-1:0]  cnt_q;
  logic [DIST_W-1:0] maxr_q, rad_q, inf_q;
  logic [VAR_W-1:0]  rvar_q, qvar_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= RST_CHANNEL_COUNT;
      maxr_q <= RST_MAX_RANGE;
      rad_q  <= RST_RING_RADIUS;
      inf_q  <= RST_INFINITY;
      rvar_q <= RST_MEAS_VAR;
      qvar_q <= RST_PROC_VAR;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_CHANNEL_COUNT: cnt_q  <= cfg_wdata_i[CNT_W-1:0];
        REG_MAX_RANGE:     maxr_q <= cfg_wdata_i[DIST_W-1:0];
        REG_RING_RADIUS:   rad_q  <= cfg_wdata_i[DIST_W-1:0];
        REG_INFINITY:      inf_q  <= cfg_wdata_i[DIST_W-1:0];
        REG_MEAS_VAR:      rvar_q <= cfg_wdata_i[VAR_W-1:0];
        REG_PROC_VAR:      qvar_q <= cfg_wdata_i[VAR_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic            en, hazard, acc, bad_d;
  logic            out_valid_q;
  logic            v_q   [0:NS-1];
  logic [CH_W-1:0] ch_q  [0:NS-1];
  logic            bad_q [0:NS-1];
  logic            end_q [0:NS-1];

  assign en = !(out_valid_q && out_stall_i);

  always_comb begin
    hazard = 1'b0;
    for (int s = 0; s <= S_WB; s++) begin
      if (v_q[s] && !bad_q[s] && (ch_q[s] == channel_i)) begin
        hazard = 1'b1;
      end
    end
  end

  assign in_stall_o = !en || hazard;
  assign acc        = in_valid_i && !in_stall_o;
  assign bad_d      = (CNT_W'(channel_i) >= cnt_q) || (32'(channel_i) >= 32'(MAX_CHANNELS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NS; s++) begin
        v_q[s] <= 1'b0;
      end
    end else if (en) begin
      v_q[0] <= acc;
      for (int s = 1; s < NS; s++) begin
        v_q[s] <= v_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ch_q[0]  <= channel_i;
      bad_q[0] <= bad_d;
      end_q[0] <= scan_end_i;
      for (int s = 1; s < NS; s++) begin
        ch_q[s]  <= ch_q[s-1];
        bad_q[s] <= bad_q[s-1];
        end_q[s] <= end_q[s-1];
      end
    end
  end

  // per-channel state
  logic                    we;
  logic [IW-1:0]           raddr, waddr;
  logic [ST_W-1:0]         rdata;
  logic                    vld_q [MAX_CHANNELS];
  logic                    rd_vld_q;
  logic [DIST_W-1:0]       est_wb;
  logic [VAR_W-1:0]        p_wb;

  assign raddr = IW'(channel_i);
  assign waddr = IW'(ch_q[S_WB]);
  assign we    = en && v_q[S_WB] && !bad_q[S_WB];

  irk_ram #(
    .WIDTH (ST_W),
    .DEPTH (MAX_CHANNELS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i ({est_wb, p_wb}),
    .re_i    (en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        vld_q[c] <= 1'b0;
      end
      rd_vld_q <= 1'b0;
    end else begin
      if (we) begin
        vld_q[waddr] <= 1'b1;
      end
      if (en) begin
        rd_vld_q <= vld_q[raddr];
      end
    end
  end

  // prediction
  logic [DIST_W-1:0] est0;
  logic [VAR_W-1:0]  p0, p1_d;
  logic [VAR_W:0]    psum, den_d, den_q;
  logic [DIST_W-1:0] est_q [1:S_UPD];
  logic [VAR_W-1:0]  p1_q  [1:S_UPD];

  always_comb begin
    est0  = rd_vld_q ? rdata[ST_W-1:VAR_W] : RST_ESTIMATE;
    p0    = rd_vld_q ? rdata[VAR_W-1:0] : RST_COVARIANCE;
    psum  = {1'b0, p0} + {1'b0, qvar_q};
    p1_d  = psum[VAR_W] ? VAR_MAX : psum[VAR_W-1:0];
    den_d = {1'b0, p1_d} + {1'b0, rvar_q};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      est_q[1] <= est0;
      p1_q[1]  <= p1_d;
      den_q    <= den_d;
      for (int s = 2; s <= S_UPD; s++) begin
        est_q[s] <= est_q[s-1];
        p1_q[s]  <= p1_q[s-1];
      end
    end
  end

  // linearisation and gain
  logic [DIST_W-1:0] dist_poly;
  logic [GAIN_W-1:0] gain;
  logic [DIST_W-1:0] r_q [S_UPD:S_REP];
  logic [DIST_W-1:0] e_q;

  irk_poly #(
    .RAW_BITS (RAW_BITS)
  ) u_poly (
    .clk_i  (clk_i),
    .en_i   (en),
    .raw_i  (raw_reading_i),
    .dist_o (dist_poly)
  );

  irk_div u_div (
    .clk_i  (clk_i),
    .en_i   (en),
    .p1_i   (p1_q[1]),
    .den_i  (den_q),
    .gain_o (gain)
  );

  irk_kupd u_kupd (
    .clk_i  (clk_i),
    .en_i   (en),
    .dist_i (r_q[S_UPD]),
    .est_i  (est_q[S_UPD]),
    .p1_i   (p1_q[S_UPD]),
    .gain_i (gain),
    .est_o  (est_wb),
    .p_o    (p_wb)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_q[S_UPD] <= dist_poly;
      for (int s = S_UPD + 1; s <= S_REP; s++) begin
        r_q[s] <= r_q[s-1];
      end
      e_q <= est_wb;
    end
  end

  // report
  logic [CH_W-1:0]   slot_d;
  logic [DIST_W-1:0] fd_d, cd_d;
  logic [DIST_W:0]   fsum, csum;
  logic [CNT_W-1:0]  slot_w;

  always_comb begin
    slot_w = cnt_q - CNT_W'(1) - CNT_W'(ch_q[S_REP]);
    fsum   = {1'b0, e_q} + {1'b0, rad_q};
    csum   = {1'b0, r_q[S_REP]} + {1'b0, rad_q};
    slot_d = '0;
    fd_d   = '0;
    cd_d   = '0;
    if (!bad_q[S_REP]) begin
      slot_d = slot_w[CH_W-1:0];
      if (e_q <= maxr_q) begin
        fd_d = fsum[DIST_W] ? DIST_MAX : fsum[DIST_W-1:0];
        cd_d = csum[DIST_W] ? DIST_MAX : csum[DIST_W-1:0];
      end else begin
        fd_d = inf_q;
        cd_d = inf_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v_q[S_REP];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      slot_o               <= slot_d;
      filtered_distance_o  <= fd_d;
      converted_distance_o <= cd_d;
      scan_end_out_o       <= end_q[S_REP];
      bad_channel_o        <= bad_q[S_REP];
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> sv/irk_checker.sv
// ----------------------------------------------------------------------------
// IR ranger Kalman filter - port checker
// Output hold, back-pressure, bad channel and reset checks, bound to the top.
// ----------------------------------------------------------------------------
`include "ir_range_linearize_kalman_assert.svh"

module irk_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [irk_pkg::CH_W-1:0]   slot_o,
  input logic [irk_pkg::DIST_W-1:0] filtered_distance_o,
  input logic [irk_pkg::DIST_W-1:0] converted_distance_o,
  input logic                       scan_end_out_o,
  input logic                       bad_channel_o
);

  `IRLK_ASSERT(a_bad_zero,
    out_valid_o && bad_channel_o |-> slot_o == '0 && filtered_distance_o == '0 &&
    converted_distance_o == '0,
    "bad channel beat with non-zero fields")

  `IRLK_ASSERT(a_out_hold,
    out_valid_o && out_stall_i |=> out_valid_o && $stable(slot_o) &&
    $stable(filtered_distance_o) && $stable(converted_distance_o) &&
    $stable(scan_end_out_o) && $stable(bad_channel_o),
    "stalled output beat changed")

  `IRLK_ASSERT(a_backpressure, out_valid_o && out_stall_i |-> in_stall_o,
    "input taken while output stalled")

  `IRLK_ASSERT_RST(a_reset_empty, !rst_ni |=> !out_valid_o,
    "output beat straight after reset")

endmodule

bind ir_range_linearize_kalman irk_checker u_irk_checker (.*);
